[rtl/core/bba_pkg.sv]
package bba_pkg;

  localparam int ORDER_TOP   = 10;
  localparam int BLOCK_SHIFT = 12;
  localparam int NBLK        = 1 << ORDER_TOP;
  localparam int NORD        = ORDER_TOP + 1;
  localparam int AW          = ORDER_TOP;
  localparam int LW          = AW + 1;
  localparam int OW          = 4;
  localparam int HDR_W       = 12;
  localparam int REQ_W       = 23;
  localparam int SUM_W       = REQ_W + 1;
  localparam int QW          = SUM_W - BLOCK_SHIFT;
  localparam int SW          = 4;
  localparam int STEP_W      = 3;

  localparam logic [LW-1:0]    NIL        = LW'(NBLK);
  localparam logic [OW-1:0]    MAX_O      = OW'(ORDER_TOP);
  localparam logic [HDR_W-1:0] HDR_RESET  = HDR_W'(32);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic [SW-1:0] S_CLEAR = 4'd0;
  localparam logic [SW-1:0] S_IDLE  = 4'd1;
  localparam logic [SW-1:0] S_DEC   = 4'd2;
  localparam logic [SW-1:0] S_SRCH  = 4'd3;
  localparam logic [SW-1:0] S_ARD   = 4'd4;
  localparam logic [SW-1:0] S_SPLIT = 4'd5;
  localparam logic [SW-1:0] S_GRANT = 4'd6;
  localparam logic [SW-1:0] S_FRD   = 4'd7;
  localparam logic [SW-1:0] S_FCHK  = 4'd8;
  localparam logic [SW-1:0] S_PUSH  = 4'd9;
  localparam logic [SW-1:0] S_MRD   = 4'd10;
  localparam logic [SW-1:0] S_MCHK  = 4'd11;
  localparam logic [SW-1:0] S_MERGE = 4'd12;
  localparam logic [SW-1:0] S_FIN   = 4'd13;

  localparam logic [STEP_W-1:0] SPLIT_LAST = 3'd3;
  localparam logic [STEP_W-1:0] GRANT_LAST = 3'd1;
  localparam logic [STEP_W-1:0] PUSH_LAST  = 3'd1;
  localparam logic [STEP_W-1:0] MERGE_LAST = 3'd5;

  typedef struct packed {
    logic             op;
    logic [REQ_W-1:0] req_bytes;
    logic [AW-1:0]    free_block;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [AW-1:0] block_index;
    logic [OW-1:0] block_order;
  } bba_out_t;

  typedef struct packed {
    logic [SW-1:0]     state;
    logic [STEP_W-1:0] step;
    logic              accept;
    logic              load_out;
  } bba_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic zero;
    logic too_big;
    logic found;
    logic split;
    logic alloc_ok;
    logic push_more;
    logic mergeable;
    logic merge_more;
  } bba_stat_t;

endpackage

[rtl/core/bba_ram.sv]
module bba_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] wa,
  input  logic [W-1:0]         wd,
  input  logic [$clog2(D)-1:0] ra,
  output logic [W-1:0]         rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

[rtl/core/bba_ctrl.sv]
module bba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bba_pkg::bba_stat_t stat,
  output bba_pkg::bba_cmd_t  cmd
);
  import bba_pkg::*;

  logic [SW-1:0]     state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              load_out;

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clr_done) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_DEC;
      S_DEC: begin
        priority if (stat.is_free) state_next = S_FRD;
        else if (stat.zero || stat.too_big) state_next = S_FIN;
        else state_next = S_SRCH;
      end
      S_SRCH:  state_next = stat.found ? S_ARD : S_FIN;
      S_ARD:   state_next = stat.split ? S_SPLIT : S_GRANT;
      S_SPLIT: if (step == SPLIT_LAST) state_next = S_ARD;
      S_GRANT: if (step == GRANT_LAST) state_next = S_FIN;
      S_FRD:   state_next = S_FCHK;
      S_FCHK:  state_next = stat.alloc_ok ? S_PUSH : S_FIN;
      S_PUSH:  if (step == PUSH_LAST) state_next = stat.push_more ? S_MRD : S_FIN;
      S_MRD:   state_next = S_MCHK;
      S_MCHK:  state_next = stat.mergeable ? S_MERGE : S_FIN;
      S_MERGE: if (step == MERGE_LAST) state_next = stat.merge_more ? S_MRD : S_FIN;
      S_FIN:   if (load_out) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  assign step_next = (state_next != state) ? '0 : step + STEP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd.state    = state;
    cmd.step     = step;
    cmd.accept   = in_valid && in_ready;
    cmd.load_out = load_out;
  end

endmodule

[rtl/core/bba_dp.sv]
module bba_dp #(
  parameter logic [bba_pkg::HDR_W-1:0] HDR_INIT = bba_pkg::HDR_RESET
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bba_pkg::bba_cmd_t           cmd,
  input  bba_pkg::bba_in_t            in_data,
  input  logic                        cfg_we,
  input  logic [bba_pkg::HDR_W-1:0]   cfg_data,
  output bba_pkg::bba_stat_t          stat,
  output bba_pkg::bba_out_t           out_data
);
  import bba_pkg::*;

  localparam logic [AW-1:0] ONE_A = AW'(1);

  logic [HDR_W-1:0] hdr;
  logic             op;
  logic [REQ_W-1:0] req;
  logic [AW-1:0]    fb;
  logic [OW-1:0]    k, j, o;
  logic [AW-1:0]    b;
  logic [LW-1:0]    bnext, nreg, preg;
  logic [LW-1:0]    head [NORD];
  logic [AW-1:0]    clr_addr;
  bba_out_t         res;

  logic [SUM_W-1:0] total, tm1;
  logic [QW-1:0]    q;
  logic [OW-1:0]    kc, jn;
  logic             found;

  logic [OW-1:0] jm1, op1, ord_clamp;
  logic [AW-1:0] lft, rgt, bit_o, bud, mleft, mright;
  logic [LW-1:0] h_lo, h_o, h2, p_fix, head_o_new;

  logic          we_ord, we_all, we_fr, we_nx, we_pv;
  logic [AW-1:0] wa_ord, wa_all, wa_fr, wa_nx, wa_pv, ra;
  logic [OW-1:0] wd_ord, rd_ord;
  logic          wd_all, wd_fr, rd_all, rd_fr;
  logic [LW-1:0] wd_nx, wd_pv, rd_nx, rd_pv;

  assign total = {1'b0, req} + SUM_W'(hdr);
  assign tm1   = total - SUM_W'(1);
  assign q     = tm1[SUM_W-1:BLOCK_SHIFT];

  always_comb begin
    kc = '0;
    for (int i = 0; i < QW; i++) begin
      if (q[i]) kc = OW'(i + 1);
    end
  end

  always_comb begin
    jn    = '0;
    found = 1'b0;
    for (int i = ORDER_TOP; i >= 0; i--) begin
      if (OW'(i) >= k && !head[i][AW]) begin
        jn    = OW'(i);
        found = 1'b1;
      end
    end
  end

  assign jm1       = j - OW'(1);
  assign op1       = o + OW'(1);
  assign lft       = head[j][AW-1:0];
  assign rgt       = lft + (ONE_A << jm1);
  assign h_lo      = head[jm1];
  assign h_o       = head[o];
  assign h2        = head[op1];
  assign bit_o     = ONE_A << o;
  assign bud       = b ^ bit_o;
  assign mleft     = b & ~bit_o;
  assign mright    = b | bit_o;
  assign ord_clamp = (rd_ord > MAX_O) ? MAX_O : rd_ord;
  assign p_fix     = (rd_pv == {1'b0, b}) ? NIL : rd_pv;
  assign head_o_new = preg[AW] ? nreg : bnext;

  always_comb begin
    stat.clr_done   = (clr_addr == AW'(NBLK - 1));
    stat.is_free    = (op == OP_FREE);
    stat.zero       = (req == '0);
    stat.too_big    = (kc > MAX_O);
    stat.found      = found;
    stat.split      = (j > k);
    stat.alloc_ok   = rd_all;
    stat.push_more  = (o < MAX_O);
    stat.mergeable  = rd_fr && (rd_ord == o);
    stat.merge_more = (op1 < MAX_O);
  end

  always_comb begin
    unique case (cmd.state)
      S_ARD:   ra = lft;
      S_FRD:   ra = fb;
      S_MRD:   ra = bud;
      default: ra = '0;
    endcase
  end

  always_comb begin
    we_ord = 1'b0; wa_ord = '0; wd_ord = '0;
    we_all = 1'b0; wa_all = '0; wd_all = 1'b0;
    we_fr  = 1'b0; wa_fr  = '0; wd_fr  = 1'b0;
    we_nx  = 1'b0; wa_nx  = '0; wd_nx  = NIL;
    we_pv  = 1'b0; wa_pv  = '0; wd_pv  = NIL;
    unique case (cmd.state)
      S_CLEAR: begin
        we_ord = 1'b1; wa_ord = clr_addr;
        wd_ord = (clr_addr == '0) ? MAX_O : '0;
        we_all = 1'b1; wa_all = clr_addr;
        we_fr  = 1'b1; wa_fr  = clr_addr; wd_fr = (clr_addr == '0);
        we_nx  = 1'b1; wa_nx  = clr_addr;
        we_pv  = 1'b1; wa_pv  = clr_addr;
      end
      S_SPLIT: begin
        unique case (cmd.step)
          3'd0: begin
            we_pv = 1'b1; wa_pv = lft;
            we_nx = 1'b1; wa_nx = lft; wd_nx = {1'b0, rgt};
            we_fr = 1'b1; wa_fr = lft; wd_fr = 1'b1;
            we_ord = 1'b1; wa_ord = lft; wd_ord = jm1;
          end
          3'd1: begin
            we_pv = 1'b1; wa_pv = rgt; wd_pv = {1'b0, lft};
            we_nx = 1'b1; wa_nx = rgt; wd_nx = h_lo;
            we_fr = 1'b1; wa_fr = rgt; wd_fr = 1'b1;
            we_ord = 1'b1; wa_ord = rgt; wd_ord = jm1;
          end
          3'd2: begin
            we_pv = !nreg[AW]; wa_pv = nreg[AW-1:0];
          end
          3'd3: begin
            we_pv = !h_lo[AW]; wa_pv = h_lo[AW-1:0]; wd_pv = {1'b0, rgt};
          end
          default: begin
          end
        endcase
      end
      S_GRANT: begin
        unique case (cmd.step)
          3'd0: begin
            we_pv  = 1'b1; wa_pv  = lft;
            we_nx  = 1'b1; wa_nx  = lft;
            we_fr  = 1'b1; wa_fr  = lft; wd_fr = 1'b0;
            we_all = 1'b1; wa_all = lft; wd_all = 1'b1;
          end
          3'd1: begin
            we_pv = !nreg[AW]; wa_pv = nreg[AW-1:0];
          end
          default: begin
          end
        endcase
      end
      S_PUSH: begin
        unique case (cmd.step)
          3'd0: begin
            we_all = 1'b1; wa_all = b; wd_all = 1'b0;
            we_pv  = 1'b1; wa_pv  = b;
            we_nx  = 1'b1; wa_nx  = b; wd_nx = h_o;
            we_fr  = 1'b1; wa_fr  = b; wd_fr = 1'b1;
            we_ord = 1'b1; wa_ord = b; wd_ord = o;
          end
          3'd1: begin
            we_pv = !h_o[AW]; wa_pv = h_o[AW-1:0]; wd_pv = {1'b0, b};
          end
          default: begin
          end
        endcase
      end
      S_MERGE: begin
        unique case (cmd.step)
          3'd0: begin
            we_pv = !bnext[AW]; wa_pv = bnext[AW-1:0];
            we_nx = 1'b1; wa_nx = b;
            we_fr = 1'b1; wa_fr = b; wd_fr = 1'b0;
            we_ord = 1'b1; wa_ord = mright; wd_ord = '0;
          end
          3'd1: begin
            we_pv = 1'b1; wa_pv = b;
            we_nx = !preg[AW]; wa_nx = preg[AW-1:0]; wd_nx = nreg;
            we_fr = 1'b1; wa_fr = bud; wd_fr = 1'b0;
            we_ord = 1'b1; wa_ord = mleft; wd_ord = op1;
          end
          3'd2: begin
            we_pv = !nreg[AW]; wa_pv = nreg[AW-1:0]; wd_pv = preg;
            we_nx = 1'b1; wa_nx = bud;
            we_fr = 1'b1; wa_fr = mleft; wd_fr = 1'b1;
          end
          3'd3: begin
            we_pv = 1'b1; wa_pv = bud;
            we_nx = 1'b1; wa_nx = mleft; wd_nx = h2;
          end
          3'd4: begin
            we_pv = 1'b1; wa_pv = mleft;
          end
          3'd5: begin
            we_pv = !h2[AW]; wa_pv = h2[AW-1:0]; wd_pv = {1'b0, mleft};
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr      <= HDR_INIT;
      clr_addr <= '0;
      for (int i = 0; i < NORD; i++) begin
        head[i] <= (i == ORDER_TOP) ? '0 : NIL;
      end
    end else begin
      if (cfg_we) hdr <= cfg_data;
      if (cmd.state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      unique case (cmd.state)
        S_GRANT: if (cmd.step == GRANT_LAST) head[j] <= nreg;
        S_SPLIT: begin
          if (cmd.step == SPLIT_LAST) begin
            head[j]   <= nreg;
            head[jm1] <= {1'b0, lft};
          end
        end
        S_PUSH: if (cmd.step == PUSH_LAST) head[o] <= {1'b0, b};
        S_MERGE: begin
          if (cmd.step == MERGE_LAST) begin
            head[o]   <= head_o_new;
            head[op1] <= {1'b0, mleft};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op  <= in_data.op;
      req <= in_data.req_bytes;
      fb  <= in_data.free_block;
    end
    if (cmd.load_out) out_data <= res;
    unique case (cmd.state)
      S_DEC: begin
        k <= kc;
        if (stat.zero) res <= '{ST_ZERO, '0, '0};
        else res <= '{ST_NOMEM, '0, '0};
      end
      S_SRCH: begin
        j <= jn;
        res <= '{ST_NOMEM, '0, '0};
      end
      S_SPLIT: begin
        if (cmd.step == 3'd0) nreg <= rd_nx;
        if (cmd.step == SPLIT_LAST) j <= jm1;
      end
      S_GRANT: begin
        if (cmd.step == 3'd0) nreg <= rd_nx;
        res <= '{ST_OK, lft, j};
      end
      S_FCHK: begin
        b   <= fb;
        o   <= ord_clamp;
        res <= '{ST_BADFREE, fb, '0};
      end
      S_PUSH: begin
        if (cmd.step == 3'd0) bnext <= h_o;
        res <= '{ST_OK, b, o};
      end
      S_MCHK: begin
        preg <= p_fix;
        nreg <= rd_nx;
        res  <= '{ST_OK, b, o};
      end
      S_MERGE: begin
        if (cmd.step == MERGE_LAST) begin
          b     <= mleft;
          bnext <= h2;
          o     <= op1;
          res   <= '{ST_OK, mleft, op1};
        end
      end
      default: begin
      end
    endcase
  end

  bba_ram #(.W(OW), .D(NBLK)) u_ord (
    .clk(clk), .we(we_ord), .wa(wa_ord), .wd(wd_ord), .ra(ra), .rd(rd_ord)
  );
  bba_ram #(.W(1), .D(NBLK)) u_all (
    .clk(clk), .we(we_all), .wa(wa_all), .wd(wd_all), .ra(ra), .rd(rd_all)
  );
  bba_ram #(.W(1), .D(NBLK)) u_fr (
    .clk(clk), .we(we_fr), .wa(wa_fr), .wd(wd_fr), .ra(ra), .rd(rd_fr)
  );
  bba_ram #(.W(LW), .D(NBLK)) u_nx (
    .clk(clk), .we(we_nx), .wa(wa_nx), .wd(wd_nx), .ra(ra), .rd(rd_nx)
  );
  bba_ram #(.W(LW), .D(NBLK)) u_pv (
    .clk(clk), .we(we_pv), .wa(wa_pv), .wd(wd_pv), .ra(ra), .rd(rd_pv)
  );

endmodule

[rtl/core/buddy_block_allocator.sv]
// Binary buddy allocator over 1024 blocks of 4096 bytes, with per-order free lists.
// Requests arrive as beats on the in channel (in_valid/in_ready): an allocate carries a
// byte size, a free carries a block start index. Each request yields exactly one result
// beat on the out channel (out_valid/out_ready) with a status, a block index and an order.
// The header size is written through the cfg channel (cfg_valid/cfg_ready), which is
// always ready; write it only while no request is in flight.
// One request is handled at a time. A granted allocate works through one split per level,
// a granted free through one merge per level while the buddy is free at the same order;
// rejected requests finish early. The block is ready for the next request in the cycle
// after the result is loaded. The list relinking goes through single-port writes to the
// block tables, one write per table per cycle.
// A finished result sits in an output register, held while out_ready is low; the next request
// may start meanwhile, but its result waits in the finish state until that register is free.
// After reset the block tables are cleared entry by entry, during which in_ready is low.
module buddy_block_allocator #(
  parameter logic [bba_pkg::HDR_W-1:0] HDR_INIT = bba_pkg::HDR_RESET
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bba_pkg::bba_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bba_pkg::bba_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bba_pkg::HDR_W-1:0] cfg_data
);
  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t stat;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  bba_dp #(.HDR_INIT(HDR_INIT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_data(in_data),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .stat(stat), .out_data(out_data)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.state) == S_FIN)
    else $error("result raised outside the finish state");

  a_block_aligned: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_OK) |->
      (out_data.block_order <= MAX_O) &&
      (((out_data.block_index >> out_data.block_order) << out_data.block_order)
        == out_data.block_index))
    else $error("granted block is not aligned to its order");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

import bba_pkg::*;

class alloc_scoreboard;
  localparam int NB = 1 << ORDER_TOP;

  logic [11:0] hdr;
  logic [3:0]  blk_order [NB];
  bit          taken [NB];
  bit          on_list [NB];
  int          nxt [NB];
  int          prv [NB];
  int          head [ORDER_TOP + 1];
  int          cnt [ORDER_TOP + 1];
  bba_out_t    pending [$];
  int          errors;
  int          reported;

  function void reset_state();
    hdr = HDR_RESET;
    for (int i = 0; i < NB; i++) begin
      blk_order[i] = 0;
      taken[i] = 0;
      on_list[i] = 0;
      nxt[i] = NB;
      prv[i] = NB;
    end
    for (int i = 0; i <= ORDER_TOP; i++) begin
      head[i] = NB;
      cnt[i] = 0;
    end
    push_block(0, ORDER_TOP);
    pending.delete();
    errors = 0;
    reported = 0;
  endfunction

  function void push_block(int b, int o);
    int h;
    h = head[o];
    prv[b] = NB;
    nxt[b] = h;
    if (h < NB) prv[h] = b;
    head[o] = b;
    cnt[o]++;
    on_list[b] = 1;
    blk_order[b] = 4'(o);
  endfunction

  function void unlink_block(int b, int o);
    int p;
    int n;
    p = prv[b];
    n = nxt[b];
    if (p < NB) nxt[p] = n;
    else head[o] = n;
    if (n < NB) prv[n] = p;
    if (cnt[o] > 0) cnt[o]--;
    prv[b] = NB;
    nxt[b] = NB;
    on_list[b] = 0;
  endfunction

  function bba_out_t serve(bba_in_t req);
    bba_out_t r;
    longint total;
    int k;
    int j;
    int b;
    int o;
    int bud;
    int lo;
    int hi;
    r = '0;
    if (req.op == OP_ALLOC) begin
      if (req.req_bytes == 0) begin
        r.status = ST_ZERO;
        return r;
      end
      total = longint'(req.req_bytes) + hdr;
      for (k = 0; k <= ORDER_TOP; k++)
        if ((longint'(1) << (BLOCK_SHIFT + k)) >= total) break;
      r.status = ST_NOMEM;
      if (k > ORDER_TOP) return r;
      for (j = k; j <= ORDER_TOP; j++)
        if (cnt[j] != 0 && head[j] < NB) break;
      if (j > ORDER_TOP) return r;
      while (j > k) begin
        lo = head[j];
        hi = (lo + (1 << (j - 1))) & (NB - 1);
        unlink_block(lo, j);
        push_block(hi, j - 1);
        push_block(lo, j - 1);
        j--;
      end
      b = head[k];
      unlink_block(b, k);
      taken[b] = 1;
      r.status = ST_OK;
      r.block_index = AW'(b);
      r.block_order = OW'(k);
    end else begin
      b = req.free_block;
      if (!taken[b]) begin
        r.status = ST_BADFREE;
        r.block_index = AW'(b);
        return r;
      end
      o = blk_order[b];
      if (o > ORDER_TOP) o = ORDER_TOP;
      taken[b] = 0;
      push_block(b, o);
      while (o < ORDER_TOP) begin
        bud = b ^ (1 << o);
        if (!on_list[bud] || blk_order[bud] != o) break;
        unlink_block(b, o);
        unlink_block(bud, o);
        lo = (b < bud) ? b : bud;
        hi = (b < bud) ? bud : b;
        blk_order[hi] = 0;
        push_block(lo, o + 1);
        b = lo;
        o++;
      end
      r.status = ST_OK;
      r.block_index = AW'(b);
      r.block_order = OW'(o);
    end
    return r;
  endfunction

  function void note_request(bba_in_t req);
    pending.push_back(serve(req));
  endfunction

  function void check_result(bba_out_t got);
    bba_out_t want;
    if (pending.size() == 0) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("Unexpected result beat: status %0d index %0d order %0d",
                 got.status, got.block_index, got.block_order);
      end
      return;
    end
    want = pending.pop_front();
    if (want !== got) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("Result mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                 want.status, want.block_index, want.block_order,
                 got.status, got.block_index, got.block_order);
      end
    end
  endfunction
endclass

module tb_top;
  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  bba_in_t         in_data;
  logic            out_valid;
  logic            out_ready;
  bba_out_t        out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [HDR_W-1:0] cfg_data;

  alloc_scoreboard sb;
  bit              quiet;
  bit              hold_off;
  int              live_blocks [$];

  buddy_block_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_request(bba_in_t req);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  task automatic write_header(logic [HDR_W-1:0] value);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.hdr = value;
  endtask

  function automatic bba_in_t alloc_req(int bytes);
    bba_in_t r;
    r = '0;
    r.op = OP_ALLOC;
    r.req_bytes = REQ_W'(bytes);
    r.free_block = AW'($urandom);
    return r;
  endfunction

  function automatic bba_in_t free_req(int blk);
    bba_in_t r;
    r = '0;
    r.op = OP_FREE;
    r.req_bytes = REQ_W'($urandom);
    r.free_block = AW'(blk);
    return r;
  endfunction

  function automatic int random_size();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick == 1) return $urandom_range(0, (1 << REQ_W) - 1);
    if (pick < 14) return $urandom_range(1, 4096 * 4);
    return $urandom_range(1, 4096 << $urandom_range(2, 9));
  endfunction

  task automatic random_traffic(int n);
    bba_out_t exp;
    int idx;
    for (int i = 0; i < n; i++) begin
      if (live_blocks.size() != 0 && $urandom_range(0, 9) < 5) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        send_request(free_req(live_blocks[idx]));
        live_blocks.delete(idx);
      end else if ($urandom_range(0, 19) == 0) begin
        send_request(free_req($urandom_range(0, 1023)));
        foreach (live_blocks[j])
          if (!sb.taken[live_blocks[j]]) begin
            live_blocks.delete(j);
            break;
          end
      end else begin
        send_request(alloc_req(random_size()));
        exp = sb.pending[$];
        if (exp.status == ST_OK) live_blocks.push_back(exp.block_index);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    out_ready <= 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 0;
      else if (quiet) out_ready <= 1;
      else if ($urandom_range(0, 4) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(0, 15)) @(posedge clk);
      end else out_ready <= 1;
    end
  end

  initial begin
    bba_out_t exp;
    sb = new();
    sb.reset_state();
    quiet = 0;
    hold_off = 0;
    rst <= 1;
    in_valid <= 0;
    in_data <= '0;
    cfg_valid <= 0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 0;

    send_request(alloc_req(0));
    send_request(alloc_req((1 << REQ_W) - 1));
    send_request(alloc_req(4096 * 1024 - 32));
    send_request(free_req(0));
    send_request(free_req(0));
    send_request(free_req(1023));
    for (int i = 0; i < 6; i++) begin
      send_request(alloc_req(1));
      exp = sb.pending[$];
      if (exp.status == ST_OK) live_blocks.push_back(exp.block_index);
    end
    send_request(alloc_req(4096 * 512));
    send_request(alloc_req(4096 * 1024));
    send_request(free_req(1));
    while (live_blocks.size() != 0) begin
      send_request(free_req(live_blocks.pop_front()));
    end
    for (int i = 0; i < 256; i++) send_request(alloc_req(4096 * 4 - 32));
    send_request(alloc_req(4096 * 4 - 32));
    for (int i = 0; i < 1024; i += 8) send_request(free_req(i));
    send_request(alloc_req(4096 * 4));
    for (int i = 4; i < 1024; i += 8) send_request(free_req(i));

    write_header(0);
    send_request(alloc_req(4096 * 1024));
    send_request(free_req(0));
    write_header(12'hFFF);
    send_request(alloc_req(1));
    exp = sb.pending[$];
    if (exp.status == ST_OK) live_blocks.push_back(exp.block_index);
    random_traffic(100);

    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_traffic(10);
    join
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);

    write_header(32);
    random_traffic(200);
    write_header(HDR_W'($urandom_range(1, 4094)));
    random_traffic(150);
    quiet = 1;
    random_traffic(80);
    in_valid <= 0;

    fork
      begin
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
      end
    join_any
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
